// File: rtl/aphs_pkg.sv
// ----------------------------------------------------------------------------
// Actuator PIO handshake sequencer package
// Shared types, codes and reset values for the sequencer and its submodules.
// ----------------------------------------------------------------------------
package aphs_pkg;

	// Configuration register file
	localparam int unsigned NUM_CFG      = 6;
	localparam int unsigned CFG_WIDTH    = 16;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned DELAY_WIDTH  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STROBE_SETUP  = 3'd0,
		CFG_STROBE_HOLD   = 3'd1,
		CFG_MOVE_SETTLE   = 3'd2,
		CFG_HOME_HOLD     = 3'd3,
		CFG_ALARM_HOLD    = 3'd4,
		CFG_RELEASE_SETTLE = 3'd5
	} aphs_cfg_idx_t;

	typedef logic [NUM_CFG-1:0][CFG_WIDTH-1:0] aphs_cfg_t;

	// Reset values, index 0 in the lowest slot
	localparam aphs_cfg_t CFG_RESET = {16'd20, 16'd30, 16'd30, 16'd100, 16'd20, 16'd30};

	// Command codes carried by the mode field
	typedef enum logic [3:0] {
		MODE_NONE    = 4'd0,
		MODE_MOVE    = 4'd1,
		MODE_HOME    = 4'd2,
		MODE_PREPARE = 4'd3,
		MODE_CLR_ALM = 4'd4,
		MODE_PAUSE   = 4'd5,
		MODE_RESUME  = 4'd6,
		MODE_SERVO_OFF = 4'd7,
		MODE_RELEASE = 4'd8
	} aphs_mode_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE         = 5'd0,
		ST_MV_WAIT_LOW1 = 5'd1,
		ST_MV_SETUP     = 5'd2,
		ST_MV_WAIT_HIGH = 5'd3,
		ST_MV_HOLD      = 5'd4,
		ST_MV_WAIT_LOW2 = 5'd5,
		ST_MV_SETTLE    = 5'd6,
		ST_HM_WAIT1     = 5'd7,
		ST_HM_HOLD      = 5'd8,
		ST_HM_WAIT2     = 5'd9,
		ST_PR_WAIT      = 5'd10,
		ST_CA_WAIT      = 5'd11,
		ST_CA_HOLD      = 5'd12,
		ST_RL_SETTLE    = 5'd13
	} aphs_state_t;

	// Driven output lines
	typedef struct packed {
		logic bkrl;
		logic res;
		logic son;
		logic stp;
		logic home;
		logic cstr;
	} aphs_lines_t;

	// One input transfer
	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] target_pos;
		logic [7:0] current_pos;
		logic       run_enable;
		logic       pend_in;
		logic       hend_in;
		logic       sv_in;
		logic       alm_in;
	} aphs_in_t;

	// One result transfer
	typedef struct packed {
		logic [7:0] pos_code_out;
		logic       cstr_out;
		logic       home_out;
		logic       stp_out;
		logic       son_out;
		logic       res_out;
		logic       bkrl_out;
		logic       busy_res;
		logic       done_res;
		logic       success;
	} aphs_out_t;

endpackage

// File: rtl/aphs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration register file
// Six 16-bit timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module aphs_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [aphs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [aphs_pkg::CFG_WIDTH-1:0] cfg_wdata,
	output aphs_pkg::aphs_cfg_t          cfg
);
	import aphs_pkg::*;

	aphs_cfg_t cfg_q;

	// Writes to indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we && (32'(cfg_idx) < NUM_CFG)) begin
			cfg_q[cfg_idx] <= cfg_wdata;
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/aphs_seq.sv
// ----------------------------------------------------------------------------
// Handshake sequencer
// Holds the command state and line registers and works one tick per step.
// ----------------------------------------------------------------------------
module aphs_seq #(
	parameter int unsigned DELAY_WIDTH = aphs_pkg::DELAY_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  aphs_pkg::aphs_in_t  item,
	input  aphs_pkg::aphs_cfg_t cfg,
	output aphs_pkg::aphs_out_t result
);
	import aphs_pkg::*;

	localparam int unsigned LOAD_W = (DELAY_WIDTH > CFG_WIDTH) ? DELAY_WIDTH : CFG_WIDTH;

	aphs_state_t            state_q, state_d;
	logic [DELAY_WIDTH-1:0] delay_q, delay_d;
	logic [7:0]             target_q, target_d;
	logic [7:0]             pos_q, pos_d;
	aphs_lines_t            lines_q, lines_d;

	logic [CFG_WIDTH-1:0]   cfg_sel;
	logic [LOAD_W-1:0]      load_ext;
	logic [LOAD_W-1:0]      load_max;
	logic [DELAY_WIDTH-1:0] delay_load;
	logic [DELAY_WIDTH-1:0] delay_dec;
	logic                   expired;
	logic                   done;
	logic                   ok;
	logic                   run;

	assign run = item.run_enable;

	// Pick the timing register that the current state would load.
	always_comb begin
		case (state_q)
			ST_IDLE:         cfg_sel = cfg[CFG_RELEASE_SETTLE];
			ST_MV_WAIT_LOW1: cfg_sel = cfg[CFG_STROBE_SETUP];
			ST_MV_WAIT_HIGH: cfg_sel = cfg[CFG_STROBE_HOLD];
			ST_MV_WAIT_LOW2: cfg_sel = cfg[CFG_MOVE_SETTLE];
			ST_HM_WAIT1:     cfg_sel = cfg[CFG_HOME_HOLD];
			ST_CA_WAIT:      cfg_sel = cfg[CFG_ALARM_HOLD];
			default:         cfg_sel = cfg[CFG_RELEASE_SETTLE];
		endcase
	end

	// Saturate the loaded value to the counter range.
	assign load_ext   = LOAD_W'(cfg_sel);
	assign load_max   = LOAD_W'({DELAY_WIDTH{1'b1}});
	assign delay_load = (load_ext > load_max) ? DELAY_WIDTH'(load_max) :
		DELAY_WIDTH'(load_ext);

	// Running delay: counts down to zero and expires when it gets there.
	assign delay_dec = (delay_q != '0) ? (delay_q - DELAY_WIDTH'(1)) : delay_q;
	assign expired   = (delay_dec == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				case (item.mode)
					MODE_MOVE:    state_d = ST_MV_WAIT_LOW1;
					MODE_HOME:    state_d = ST_HM_WAIT1;
					MODE_PREPARE: state_d = ST_PR_WAIT;
					MODE_CLR_ALM: state_d = ST_CA_WAIT;
					MODE_RELEASE: state_d = ST_RL_SETTLE;
					default:      state_d = ST_IDLE;
				endcase
			end
			ST_MV_WAIT_LOW1: begin
				if (!run) state_d = ST_IDLE;
				else if (!item.pend_in) state_d = ST_MV_SETUP;
			end
			ST_MV_SETUP:     if (expired) state_d = ST_MV_WAIT_HIGH;
			ST_MV_WAIT_HIGH: begin
				if (!run) state_d = ST_IDLE;
				else if (item.pend_in) state_d = ST_MV_HOLD;
			end
			ST_MV_HOLD:      if (expired) state_d = ST_MV_WAIT_LOW2;
			ST_MV_WAIT_LOW2: begin
				if (!run) state_d = ST_IDLE;
				else if (!item.pend_in) state_d = ST_MV_SETTLE;
			end
			ST_MV_SETTLE:    if (expired) state_d = ST_IDLE;
			ST_HM_WAIT1: begin
				if (!run) state_d = ST_IDLE;
				else if (item.hend_in) state_d = ST_HM_HOLD;
			end
			ST_HM_HOLD:      if (expired) state_d = ST_HM_WAIT2;
			ST_HM_WAIT2:     if (!run || item.hend_in) state_d = ST_IDLE;
			ST_PR_WAIT:      if (!(run && item.sv_in)) state_d = ST_IDLE;
			ST_CA_WAIT: begin
				if (!run) state_d = ST_IDLE;
				else if (item.alm_in) state_d = ST_CA_HOLD;
			end
			ST_CA_HOLD:      if (expired) state_d = ST_IDLE;
			ST_RL_SETTLE:    if (expired) state_d = ST_IDLE;
			default:         state_d = ST_IDLE;
		endcase
	end

	// Line, counter and status outputs of each step
	always_comb begin
		lines_d  = lines_q;
		pos_d    = pos_q;
		target_d = target_q;
		delay_d  = delay_q;
		done     = 1'b0;
		ok       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				case (item.mode)
					MODE_MOVE:    target_d = item.target_pos;
					MODE_HOME:    lines_d.home = 1'b1;
					MODE_PREPARE: lines_d.son = 1'b1;
					MODE_CLR_ALM: lines_d.res = 1'b1;
					MODE_PAUSE: begin
						lines_d.stp = 1'b1;
						done = 1'b1;
						ok = 1'b1;
					end
					MODE_RESUME: begin
						lines_d.stp = 1'b0;
						done = 1'b1;
						ok = 1'b1;
					end
					MODE_SERVO_OFF: begin
						lines_d.son = 1'b0;
						done = 1'b1;
						ok = 1'b1;
					end
					MODE_RELEASE: begin
						lines_d.bkrl = 1'b0;
						lines_d.cstr = 1'b0;
						lines_d.home = 1'b0;
						lines_d.res  = 1'b0;
						lines_d.stp  = 1'b0;
						delay_d = delay_load;
					end
					default: ;
				endcase
			end
			ST_MV_WAIT_LOW1: begin
				if (!run) begin
					done = 1'b1;
				end else if (!item.pend_in) begin
					pos_d   = target_q;
					delay_d = delay_load;
				end
			end
			ST_MV_SETUP: begin
				delay_d = delay_dec;
				if (expired) lines_d.cstr = 1'b1;
			end
			ST_MV_WAIT_HIGH: begin
				if (!run) done = 1'b1;
				else if (item.pend_in) delay_d = delay_load;
			end
			ST_MV_HOLD: begin
				delay_d = delay_dec;
				if (expired) lines_d.cstr = 1'b0;
			end
			ST_MV_WAIT_LOW2: begin
				if (!run) done = 1'b1;
				else if (!item.pend_in) delay_d = delay_load;
			end
			ST_MV_SETTLE: begin
				delay_d = delay_dec;
				if (expired) begin
					done = 1'b1;
					ok = (item.current_pos == target_q);
				end
			end
			ST_HM_WAIT1: begin
				if (!run) done = 1'b1;
				else if (item.hend_in) delay_d = delay_load;
			end
			ST_HM_HOLD: begin
				delay_d = delay_dec;
				if (expired) lines_d.home = 1'b0;
			end
			ST_HM_WAIT2: begin
				if (!run) begin
					done = 1'b1;
				end else if (item.hend_in) begin
					done = 1'b1;
					ok = 1'b1;
				end
			end
			ST_PR_WAIT: begin
				if (!(run && item.sv_in)) begin
					lines_d.stp = 1'b1;
					done = 1'b1;
					ok = run;
				end
			end
			ST_CA_WAIT: begin
				if (!run) done = 1'b1;
				else if (item.alm_in) delay_d = delay_load;
			end
			ST_CA_HOLD: begin
				delay_d = delay_dec;
				if (expired) begin
					lines_d.res = 1'b0;
					done = 1'b1;
					ok = 1'b1;
				end
			end
			ST_RL_SETTLE: begin
				delay_d = delay_dec;
				if (expired) begin
					done = 1'b1;
					ok = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// State registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			delay_q  <= '0;
			target_q <= '0;
			pos_q    <= '0;
			lines_q  <= '0;
		end else if (step_en) begin
			state_q  <= state_d;
			delay_q  <= delay_d;
			target_q <= target_d;
			pos_q    <= pos_d;
			lines_q  <= lines_d;
		end
	end

	// Result of this step, taken from the updated register values
	always_comb begin
		result.pos_code_out = pos_d;
		result.cstr_out     = lines_d.cstr;
		result.home_out     = lines_d.home;
		result.stp_out      = lines_d.stp;
		result.son_out      = lines_d.son;
		result.res_out      = lines_d.res;
		result.bkrl_out     = lines_d.bkrl;
		result.busy_res     = (state_d != ST_IDLE);
		result.done_res     = done;
		result.success      = done && ok;
	end

endmodule

// File: rtl/actuator_pio_handshake_sequencer_core.sv
// ----------------------------------------------------------------------------
// Actuator PIO handshake sequencer
// Runs the timed parallel-I/O handshake of one actuator axis, one tick per
// input transfer.
// ----------------------------------------------------------------------------
// Usage
// Each input transfer on in_data is one tick: the sampled driver lines, the
// run-enable flag, the reported position and an optional command. Every input
// transfer yields exactly one result transfer on out_data with the driven
// line levels and the busy, done and success flags after that tick.
// Commands are only taken while no sequence runs; others are ignored.
// The user must write the timing registers on cfg_we/cfg_idx/cfg_wdata
// only while idle; the block itself does not enforce this. An accepted
// transfer is held in the input register, then the combinational
// sequencer step writes the result register, which raises out_valid.
// Throughput is one transfer per cycle while the receiver does not stall,
// as the sequencer step between the two registers is combinational.
// If the receiver stalls, the result register holds its transfer and the
// input register can still take one more transfer before in_ready drops.
// Reset clears the sequencer to idle with all lines low and loads the timing
// registers with their default values.
// ----------------------------------------------------------------------------
module actuator_pio_handshake_sequencer_core #(
	parameter int unsigned DELAY_WIDTH = aphs_pkg::DELAY_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  aphs_pkg::aphs_in_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output aphs_pkg::aphs_out_t            out_data,
	input  logic                           cfg_we,
	input  logic [aphs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [aphs_pkg::CFG_WIDTH-1:0] cfg_wdata
);
	import aphs_pkg::*;

	aphs_cfg_t cfg;
	aphs_in_t  item_s1;
	logic      valid_s1;
	aphs_out_t result;
	aphs_out_t out_data_q;
	logic      out_valid_q;
	logic      advance;

	// The step runs when an item waits and the result register is free.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Timing registers
	aphs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Sequencer step
	aphs_seq #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: tb/sv/tb_actuator_pio_handshake_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the actuator PIO handshake sequencer core
// Drives tick transfers with the driver line levels and commands, predicts
// the line levels and busy/done/success flags of every tick with a local
// model of the sequencer, and compares each result transfer field by field.
// Covers default, zero and maximum timing settings, back-pressure and long
// randomised runs of well-formed command sequences mixed with noise.
// ----------------------------------------------------------------------------
module tb_actuator_pio_handshake_sequencer_core;
	import aphs_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_TICKS   = 630;
	localparam int unsigned PHASE_TICKS    = 210;
	localparam int unsigned MAX_REPORTS    = 50;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	aphs_in_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	aphs_out_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [CFG_WIDTH-1:0] cfg_wdata = '0;

	// Local copy of the sequencer state and its timing registers.
	aphs_state_t          seq_st;
	logic [DELAY_WIDTH-1:0] dly;
	logic [7:0]           tgt_latch;
	logic [7:0]           pos_code;
	aphs_lines_t          lines;
	logic [CFG_WIDTH-1:0] timing [NUM_CFG];

	aphs_out_t            expected_ticks [$];

	int unsigned          errors       = 0;
	int unsigned          ticks_sent   = 0;
	int unsigned          cmds_done    = 0;
	int unsigned          cmds_ok      = 0;
	int unsigned          settings_run = 1;
	int unsigned          idle_cycles  = 0;
	int unsigned          rx_hold      = 0;
	bit                   tx_burst     = 1'b0;
	bit                   rx_burst     = 1'b0;

	actuator_pio_handshake_sequencer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Sequencer state after reset, timing registers at their defaults.
	function automatic void reset_sequencer();
		seq_st    = ST_IDLE;
		dly       = '0;
		tgt_latch = '0;
		pos_code  = '0;
		lines     = '0;
		timing[CFG_STROBE_SETUP]   = 16'd30;
		timing[CFG_STROBE_HOLD]    = 16'd20;
		timing[CFG_MOVE_SETTLE]    = 16'd100;
		timing[CFG_HOME_HOLD]      = 16'd30;
		timing[CFG_ALARM_HOLD]     = 16'd30;
		timing[CFG_RELEASE_SETTLE] = 16'd20;
	endfunction

	// A delay counts down once per tick and expires when it reaches zero.
	function automatic logic delay_expired();
		if (dly != '0)
			dly = dly - 1'b1;
		return dly == '0;
	endfunction

	// Advances the sequencer by one tick and queues the result it must give.
	function automatic void advance_sequencer(input aphs_in_t t);
		logic      fin;
		logic      ok;
		aphs_out_t r;
		fin = 1'b0;
		ok  = 1'b0;
		case (seq_st)
			ST_IDLE: begin
				case (aphs_mode_t'(t.mode))
					MODE_MOVE: begin
						tgt_latch = t.target_pos;
						seq_st    = ST_MV_WAIT_LOW1;
					end
					MODE_HOME: begin
						lines.home = 1'b1;
						seq_st     = ST_HM_WAIT1;
					end
					MODE_PREPARE: begin
						lines.son = 1'b1;
						seq_st    = ST_PR_WAIT;
					end
					MODE_CLR_ALM: begin
						lines.res = 1'b1;
						seq_st    = ST_CA_WAIT;
					end
					MODE_PAUSE: begin
						lines.stp = 1'b1;
						fin = 1'b1;
						ok  = 1'b1;
					end
					MODE_RESUME: begin
						lines.stp = 1'b0;
						fin = 1'b1;
						ok  = 1'b1;
					end
					MODE_SERVO_OFF: begin
						lines.son = 1'b0;
						fin = 1'b1;
						ok  = 1'b1;
					end
					MODE_RELEASE: begin
						lines.bkrl = 1'b0;
						lines.cstr = 1'b0;
						lines.home = 1'b0;
						lines.res  = 1'b0;
						lines.stp  = 1'b0;
						dly    = timing[CFG_RELEASE_SETTLE];
						seq_st = ST_RL_SETTLE;
					end
					default: ;
				endcase
			end
			ST_MV_WAIT_LOW1: begin
				if (!t.run_enable) begin
					fin = 1'b1;
				end else if (!t.pend_in) begin
					pos_code = tgt_latch;
					dly      = timing[CFG_STROBE_SETUP];
					seq_st   = ST_MV_SETUP;
				end
			end
			ST_MV_SETUP: begin
				if (delay_expired()) begin
					lines.cstr = 1'b1;
					seq_st     = ST_MV_WAIT_HIGH;
				end
			end
			ST_MV_WAIT_HIGH: begin
				if (!t.run_enable) begin
					fin = 1'b1;
				end else if (t.pend_in) begin
					dly    = timing[CFG_STROBE_HOLD];
					seq_st = ST_MV_HOLD;
				end
			end
			ST_MV_HOLD: begin
				if (delay_expired()) begin
					lines.cstr = 1'b0;
					seq_st     = ST_MV_WAIT_LOW2;
				end
			end
			ST_MV_WAIT_LOW2: begin
				if (!t.run_enable) begin
					fin = 1'b1;
				end else if (!t.pend_in) begin
					dly    = timing[CFG_MOVE_SETTLE];
					seq_st = ST_MV_SETTLE;
				end
			end
			ST_MV_SETTLE: begin
				if (delay_expired()) begin
					fin = 1'b1;
					ok  = (t.current_pos == tgt_latch);
				end
			end
			ST_HM_WAIT1: begin
				if (!t.run_enable) begin
					fin = 1'b1;
				end else if (t.hend_in) begin
					dly    = timing[CFG_HOME_HOLD];
					seq_st = ST_HM_HOLD;
				end
			end
			ST_HM_HOLD: begin
				if (delay_expired()) begin
					lines.home = 1'b0;
					seq_st     = ST_HM_WAIT2;
				end
			end
			ST_HM_WAIT2: begin
				if (!t.run_enable) begin
					fin = 1'b1;
				end else if (t.hend_in) begin
					fin = 1'b1;
					ok  = 1'b1;
				end
			end
			ST_PR_WAIT: begin
				// Stop is raised on exit whether or not run-enable held.
				if (!(t.run_enable && t.sv_in)) begin
					lines.stp = 1'b1;
					fin = 1'b1;
					ok  = t.run_enable;
				end
			end
			ST_CA_WAIT: begin
				if (!t.run_enable) begin
					fin = 1'b1;
				end else if (t.alm_in) begin
					dly    = timing[CFG_ALARM_HOLD];
					seq_st = ST_CA_HOLD;
				end
			end
			ST_CA_HOLD: begin
				if (delay_expired()) begin
					lines.res = 1'b0;
					fin = 1'b1;
					ok  = 1'b1;
				end
			end
			ST_RL_SETTLE: begin
				if (delay_expired()) begin
					fin = 1'b1;
					ok  = 1'b1;
				end
			end
			default: seq_st = ST_IDLE;
		endcase

		if (fin) begin
			seq_st = ST_IDLE;
			cmds_done++;
			if (ok)
				cmds_ok++;
		end

		r.pos_code_out = pos_code;
		r.cstr_out     = lines.cstr;
		r.home_out     = lines.home;
		r.stp_out      = lines.stp;
		r.son_out      = lines.son;
		r.res_out      = lines.res;
		r.bkrl_out     = lines.bkrl;
		r.busy_res     = (seq_st != ST_IDLE);
		r.done_res     = fin;
		r.success      = fin && ok;
		expected_ticks.push_back(r);
	endfunction

	// A tick with every field random.
	function automatic aphs_in_t rand_tick();
		logic [$bits(aphs_in_t)-1:0] bits;
		bits = $bits(aphs_in_t)'($urandom);
		return aphs_in_t'(bits);
	endfunction

	// Offers one tick after a random gap and predicts it once it is accepted.
	task automatic send_tick(input aphs_in_t t);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ticks_sent++;
		advance_sequencer(t);
	endtask

	task automatic tx_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_ticks.size() != 0)
			@(posedge clk);
	endtask

	// Feeds ticks until the running sequence finishes. Wait lines show the
	// awaited level unless noise says otherwise; run-enable drops per abort_pct.
	task automatic step_busy(input int unsigned noise_pct, input int unsigned abort_pct,
			input bit match_pos);
		aphs_in_t t;
		logic     wrong;
		while (seq_st != ST_IDLE) begin
			t = rand_tick();
			t.run_enable = ($urandom_range(0, 99) >= abort_pct);
			wrong = ($urandom_range(0, 99) < noise_pct);
			case (seq_st)
				ST_MV_WAIT_LOW1, ST_MV_WAIT_LOW2: t.pend_in = wrong;
				ST_MV_WAIT_HIGH:                  t.pend_in = !wrong;
				ST_HM_WAIT1, ST_HM_WAIT2:         t.hend_in = !wrong;
				ST_CA_WAIT:                       t.alm_in  = !wrong;
				ST_PR_WAIT: t.sv_in = ($urandom_range(0, 99) < 75);
				default: ;
			endcase
			if (match_pos)
				t.current_pos = tgt_latch;
			send_tick(t);
		end
	endtask

	// One command from idle through to its done tick.
	task automatic drive_sequence(input aphs_mode_t mode, input logic [7:0] tgt,
			input bit match_pos, input int unsigned noise_pct, input int unsigned abort_pct);
		aphs_in_t t;
		t = rand_tick();
		t.mode       = mode;
		t.target_pos = tgt;
		send_tick(t);
		step_busy(noise_pct, abort_pct, match_pos);
	endtask

	// Brings the block to idle with nothing in flight before a register write.
	task automatic quiesce();
		bit saved;
		saved    = tx_burst;
		tx_burst = 1'b1;
		step_busy(0, 100, 1'b0);
		tx_burst = saved;
		tx_idle();
		wait_drained();
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timing(input aphs_cfg_idx_t idx, input logic [CFG_WIDTH-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		timing[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_timing(input logic [CFG_WIDTH-1:0] val);
		for (int i = 0; i < NUM_CFG; i++)
			write_timing(aphs_cfg_idx_t'(i), val);
		settings_run++;
	endtask

	task automatic send_fields(input aphs_mode_t mode, input logic [7:0] tgt,
			input logic [7:0] cur, input logic line_lvl);
		aphs_in_t t;
		t.mode        = mode;
		t.target_pos  = tgt;
		t.current_pos = cur;
		t.run_enable  = line_lvl;
		t.pend_in     = line_lvl;
		t.hend_in     = line_lvl;
		t.sv_in       = line_lvl;
		t.alm_in      = line_lvl;
		send_tick(t);
	endtask

	// Idle ticks at the field extremes, two unknown modes, then a move and a
	// release on the timing values that reset leaves.
	task automatic test_reset_values();
		send_fields(MODE_NONE, 8'h00, 8'h00, 1'b0);
		send_fields(MODE_NONE, 8'hFF, 8'hFF, 1'b1);
		send_fields(aphs_mode_t'(4'hF), 8'hFF, 8'h00, 1'b1);
		send_fields(aphs_mode_t'(4'h9), 8'h00, 8'hFF, 1'b0);
		drive_sequence(MODE_MOVE, 8'hFF, 1'b1, 0, 0);
		drive_sequence(MODE_RELEASE, 8'h00, 1'b0, 0, 0);
		quiesce();
	endtask

	// Zero-length delays last one tick; every command, mismatch and aborts.
	task automatic test_zero_delays();
		write_all_timing(16'd0);
		drive_sequence(MODE_MOVE, 8'h00, 1'b1, 0, 0);
		drive_sequence(MODE_MOVE, 8'h00, 1'b0, 0, 0);
		drive_sequence(MODE_MOVE, 8'hA5, 1'b1, 0, 100);
		drive_sequence(MODE_HOME, 8'h00, 1'b0, 20, 0);
		drive_sequence(MODE_HOME, 8'h00, 1'b0, 0, 100);
		drive_sequence(MODE_PREPARE, 8'h00, 1'b0, 0, 0);
		drive_sequence(MODE_PREPARE, 8'h00, 1'b0, 0, 100);
		drive_sequence(MODE_CLR_ALM, 8'h00, 1'b0, 20, 0);
		drive_sequence(MODE_CLR_ALM, 8'h00, 1'b0, 0, 100);
		drive_sequence(MODE_PAUSE, 8'h00, 1'b0, 0, 0);
		drive_sequence(MODE_RESUME, 8'h00, 1'b0, 0, 0);
		drive_sequence(MODE_PREPARE, 8'h00, 1'b0, 0, 0);
		drive_sequence(MODE_SERVO_OFF, 8'h00, 1'b0, 0, 0);
		drive_sequence(MODE_MOVE, 8'h3C, 1'b1, 30, 0);
		drive_sequence(MODE_RELEASE, 8'h00, 1'b0, 0, 0);
		quiesce();
	endtask

	// Largest timing values with sequences that abort before a delay starts,
	// then one long release settle at full rate on both sides.
	task automatic test_max_delays();
		write_all_timing(16'hFFFF);
		drive_sequence(MODE_MOVE, 8'h5A, 1'b0, 0, 100);
		drive_sequence(MODE_HOME, 8'h00, 1'b0, 0, 100);
		drive_sequence(MODE_CLR_ALM, 8'h00, 1'b0, 0, 100);
		drive_sequence(MODE_PREPARE, 8'h00, 1'b0, 0, 100);
		quiesce();
		write_timing(CFG_RELEASE_SETTLE, 16'd250);
		tx_burst = 1'b1;
		rx_burst = 1'b1;
		drive_sequence(MODE_RELEASE, 8'h00, 1'b0, 0, 0);
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		quiesce();
		write_all_timing(16'd3);
	endtask

	// Receiver holds off long enough for the block to stall its input.
	task automatic test_backpressure();
		rx_hold  = 300;
		tx_burst = 1'b1;
		for (int i = 0; i < 3; i++)
			drive_sequence(MODE_MOVE, 8'($urandom), 1'b1, 10, 0);
		tx_burst = 1'b0;
		quiesce();
	endtask

	// Phases of random timing, mostly well-formed sequences with random
	// content, some noise ticks and aborted or stalled sequences.
	task automatic test_random_traffic();
		int unsigned start;
		int unsigned phase;
		int unsigned phase_start;
		bit          paused;
		start = ticks_sent;
		phase = 0;
		while (ticks_sent - start < RANDOM_TICKS) begin
			quiesce();
			for (int i = 0; i < NUM_CFG; i++)
				write_timing(aphs_cfg_idx_t'(i), ($urandom_range(0, 99) < 80) ?
					16'($urandom_range(0, 5)) : 16'($urandom_range(0, 40)));
			settings_run++;
			tx_burst    = (phase == 2);
			rx_burst    = (phase == 2);
			phase_start = ticks_sent;
			paused      = 1'b0;
			while (ticks_sent - phase_start < PHASE_TICKS) begin
				if (seq_st != ST_IDLE)
					step_busy(50, 10, 1'b0);
				else if ($urandom_range(0, 99) < 15)
					send_tick(rand_tick());
				else
					drive_sequence(aphs_mode_t'($urandom_range(1, 8)), 8'($urandom),
						$urandom_range(0, 1) == 1, $urandom_range(0, 40),
						($urandom_range(0, 99) < 85) ? 0 : 10);
				// Sender waits for every result once per phase.
				if (!paused && ticks_sent - phase_start >= PHASE_TICKS / 2) begin
					paused = 1'b1;
					tx_idle();
					wait_drained();
				end
			end
			tx_burst = 1'b0;
			rx_burst = 1'b0;
			phase++;
		end
	endtask

	// Receiver: a random number of stalled cycles before each transfer.
	initial begin : receiver
		int unsigned stall;
		wait (arst_n);
		forever begin
			stall   = (rx_burst ? 0 : $urandom_range(0, 12)) + rx_hold;
			rx_hold = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			if (errors < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Each result transfer is compared with the oldest expectation.
	always @(posedge clk) begin : result_check
		aphs_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_ticks.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %h", $time, out_data);
				errors++;
			end else begin
				want = expected_ticks.pop_front();
				check_field("pos_code_out", want.pos_code_out, out_data.pos_code_out);
				check_field("cstr_out", 8'(want.cstr_out), 8'(out_data.cstr_out));
				check_field("home_out", 8'(want.home_out), 8'(out_data.home_out));
				check_field("stp_out", 8'(want.stp_out), 8'(out_data.stp_out));
				check_field("son_out", 8'(want.son_out), 8'(out_data.son_out));
				check_field("res_out", 8'(want.res_out), 8'(out_data.res_out));
				check_field("bkrl_out", 8'(want.bkrl_out), 8'(out_data.bkrl_out));
				check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
				check_field("success", 8'(want.success), 8'(out_data.success));
			end
		end
	end

	// Watchdog: too many cycles without any transfer ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		reset_sequencer();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_zero_delays();
		test_max_delays();
		test_backpressure();
		test_random_traffic();

		tx_idle();
		wait_drained();
		repeat (20) @(posedge clk);
		if (expected_ticks.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_ticks.size());
			errors++;
		end

		$display("Run covered %0d ticks over %0d timing settings.", ticks_sent, settings_run);
		$display("%0d commands finished, %0d acknowledged; %0d mismatches.",
			cmds_done, cmds_ok, errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
rtl/aphs_pkg.sv
rtl/aphs_cfg_regs.sv
rtl/aphs_seq.sv
rtl/actuator_pio_handshake_sequencer_core.sv
tb/sv/tb_actuator_pio_handshake_sequencer_core.sv
